// File: rtl/core/coo_to_csr_row_pointers_core_assert.svh
// Assertion macros shared by the core RTL.
`ifndef COO_TO_CSR_ROW_POINTERS_CORE_ASSERT_SVH
`define COO_TO_CSR_ROW_POINTERS_CORE_ASSERT_SVH

// Same-cycle implication.
`define CCRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("core assertion failed");

// Next-cycle implication.
`define CCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("core assertion failed");

`endif

// File: rtl/core/ccrp_pkg.sv
package ccrp_pkg;

	localparam int ROW_W = 6;
	localparam int COL_W = 6;
	localparam int VAL_W = 64;
	localparam int IDX_W = 12;
	localparam int CNT_W = 13;

	localparam logic OP_ENTRY  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic KIND_ENTRY = 1'b0;
	localparam logic KIND_PTR   = 1'b1;

	// write request into the row-count store
	typedef struct packed {
		logic             we;
		logic [ROW_W-1:0] addr;
		logic [CNT_W-1:0] data;
	} ccrp_wr_t;

endpackage

// File: rtl/core/ccrp_count_store.sv
module ccrp_count_store import ccrp_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ROW_W-1:0] rd_addr,
	input  ccrp_wr_t         wr,
	input  logic             clear,
	output logic [CNT_W-1:0] rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [CNT_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] rd_q;
	logic             rd_ok_q;
	logic [AW-1:0]    ra;
	logic [AW-1:0]    wa;

	assign ra = rd_addr[AW-1:0];
	assign wa = wr.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wa] <= wr.data;
		end
		rd_q <= mem_q[ra];
	end

	// entry never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr.we) begin
				valid_q[wa] <= 1'b1;
			end
			rd_ok_q <= valid_q[ra];
		end
	end

	assign rd_data = rd_ok_q ? rd_q : '0;

endmodule

// File: rtl/core/coo_to_csr_row_pointers_core.sv
// Channel | Handshake              | Payload
// --------+------------------------+----------------------------------------------
// in      | in_valid / in_stall    | opcode, row, col, value_re, value_im
// out     | out_valid / out_stall  | kind, index, col_out, re_out, im_out, pointer,
//         |                        | error, last
// cfg     | cfg_valid / cfg_ready  | cfg_data (rows_in_use)
//
// An entry's echo is registered and its row count is updated through a registered
// read, increment, write of the count RAM, forwarded back to back.
// A finish walks the count RAM: each pointer is emitted and its row read in ST_EMIT,
// then that row's count is added in ST_ADD; input is stalled for the whole walk.
// Reset leaves every count at zero through per-row valid bits; a finish clears them
// with the final pointer. Output stall holds the result register and stalls input.
module coo_to_csr_row_pointers_core import ccrp_pkg::*; #(
	parameter int MAX_ROWS    = 63,
	parameter int MAX_ENTRIES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             opcode,
	input  logic [ROW_W-1:0] row,
	input  logic [COL_W-1:0] col,
	input  logic [VAL_W-1:0] value_re,
	input  logic [VAL_W-1:0] value_im,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             kind,
	output logic [IDX_W-1:0] index,
	output logic [COL_W-1:0] col_out,
	output logic [VAL_W-1:0] re_out,
	output logic [VAL_W-1:0] im_out,
	output logic [CNT_W-1:0] pointer,
	output logic             error,
	output logic             last,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ROW_W-1:0] cfg_data
);

	`include "coo_to_csr_row_pointers_core_assert.svh"

	localparam int DEPTH = MAX_ROWS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $clog2(MAX_ENTRIES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EMIT = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;

	logic [ROW_W-1:0] rows_in_use_q;
	logic [ROW_W-1:0] nrows;
	logic [EW-1:0]    entry_count_q;
	logic [1:0]       state_q;
	logic [AW-1:0]    r_q;
	logic [CNT_W-1:0] sum_q;

	logic             s1_vld_q;
	logic [AW-1:0]    row_s1;
	logic             wr_vld_q;
	logic [AW-1:0]    wr_row_q;
	logic [CNT_W-1:0] wr_val_q;

	logic             out_valid_q;
	logic             kind_q;
	logic [IDX_W-1:0] index_q;
	logic [COL_W-1:0] col_q;
	logic [VAL_W-1:0] re_q;
	logic [VAL_W-1:0] im_q;
	logic [CNT_W-1:0] pointer_q;
	logic             error_q;
	logic             last_q;

	logic             out_free;
	logic             in_acc;
	logic             is_entry;
	logic             ent_bad;
	logic             ent_ok;
	logic             fin_acc;
	logic             emit;
	logic             at_last;
	logic             emit_last;
	logic [ROW_W-1:0] rd_addr;
	logic [CNT_W-1:0] rd_data;
	logic             wr_hit;
	logic [CNT_W-1:0] cnt_cur;
	ccrp_wr_t         wr;

	assign nrows = (rows_in_use_q > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : rows_in_use_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign in_acc    = in_valid && !in_stall;
	assign is_entry  = (opcode == OP_ENTRY);
	assign ent_bad   = (row >= nrows) || (entry_count_q >= EW'(MAX_ENTRIES));
	assign ent_ok    = in_acc && is_entry && !ent_bad;
	assign fin_acc   = in_acc && !is_entry;
	assign at_last   = (ROW_W'(r_q) == nrows);
	assign emit      = (state_q == ST_EMIT) && out_free;
	assign emit_last = emit && at_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= ROW_W'(63);
		end else if (cfg_valid) begin
			rows_in_use_q <= cfg_data;
		end
	end

	// count RAM: entry path reads at the input row, finish walk reads at r_q
	assign rd_addr = (state_q == ST_IDLE) ? row : ROW_W'(r_q);

	// the write issued at the edge of our read is not yet visible in read data
	assign wr_hit  = wr_vld_q && (wr_row_q == row_s1);
	assign cnt_cur = wr_hit ? wr_val_q : rd_data;

	always_comb begin
		wr.we   = s1_vld_q;
		wr.addr = ROW_W'(row_s1);
		wr.data = cnt_cur + CNT_W'(1);
	end

	ccrp_count_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(rd_addr),
		.wr     (wr),
		.clear  (emit_last),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			wr_vld_q <= 1'b0;
		end else begin
			s1_vld_q <= ent_ok;
			wr_vld_q <= s1_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		row_s1   <= row[AW-1:0];
		wr_row_q <= row_s1;
		wr_val_q <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			r_q           <= '0;
			sum_q         <= '0;
		end else begin
			if (emit_last) begin
				entry_count_q <= '0;
			end else if (ent_ok) begin
				entry_count_q <= entry_count_q + EW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (fin_acc) begin
						state_q <= ST_EMIT;
						r_q     <= '0;
						sum_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= at_last ? ST_IDLE : ST_ADD;
					end
				end
				ST_ADD: begin
					sum_q   <= sum_q + rd_data;
					r_q     <= r_q + AW'(1);
					state_q <= ST_EMIT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_acc && is_entry) || emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && is_entry) begin
			kind_q    <= KIND_ENTRY;
			index_q   <= ent_bad ? '0 : IDX_W'(entry_count_q);
			col_q     <= col;
			re_q      <= value_re;
			im_q      <= value_im;
			pointer_q <= '0;
			error_q   <= ent_bad;
			last_q    <= 1'b1;
		end else if (emit) begin
			kind_q    <= KIND_PTR;
			index_q   <= IDX_W'(r_q);
			col_q     <= '0;
			re_q      <= '0;
			im_q      <= '0;
			pointer_q <= sum_q;
			error_q   <= 1'b0;
			last_q    <= at_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign index     = index_q;
	assign col_out   = col_q;
	assign re_out    = re_q;
	assign im_out    = im_q;
	assign pointer   = pointer_q;
	assign error     = error_q;
	assign last      = last_q;

	// no count update may still be in flight while the walk reads the RAM
	`CCRP_ASSERT_IMPL(a_walk_no_rmw, clk, arst_n, state_q != ST_IDLE, !s1_vld_q)
	// final pointer ends the walk and resets the entry count
	`CCRP_ASSERT_NEXT(a_last_ends_walk, clk, arst_n, emit_last, (state_q == ST_IDLE) && (entry_count_q == '0))
	`CCRP_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, entry_count_q <= EW'(MAX_ENTRIES))
	// a count update is issued only for an accepted entry
	`CCRP_ASSERT_NEXT(a_rmw_from_entry, clk, arst_n, !in_acc, !s1_vld_q)

endmodule
